@@ rtl/core/rdc_pkg.sv @@
`default_nettype none

package rdc_pkg;

  // Widths of the configuration port and of the stored register fields.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  // Default sizes of the integer and fraction parts.
  localparam int INT_BITS_DEF  = 31;
  localparam int FRAC_BITS_DEF = 32;

  // Register indexes, taken from the word address bit of paddr.
  localparam logic REG_BASE = 1'b0;
  localparam logic REG_FRAC = 1'b1;

  localparam logic [CFG_W-1:0] BASE_RESET = 5'd10;
  localparam logic [CFG_W-1:0] FRAC_RESET = 5'd6;
  localparam logic [CFG_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [CFG_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [CFG_W-1:0] FRAC_MAX   = 5'd30;

  // ASCII codes used on the character output.
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_LOWER = 7'h61;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_SPACE = 7'h20;

  // Stored configuration, as seen by the datapath.
  typedef struct packed {
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] frac_digits;
  } cfg_t;

  // Status of the shared divider towards the sequencer.
  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_res_t;

  function automatic logic [CFG_W-1:0] eff_base(input logic [CFG_W-1:0] b);
    logic [CFG_W-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] eff_limit(input logic [CFG_W-1:0] f);
    return (f > FRAC_MAX) ? FRAC_MAX : f;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] r;
    if (d > 4'd9) begin
      r = (upper ? CH_UPPER : CH_LOWER) + {3'b000, d} - 7'd10;
    end else begin
      r = CH_ZERO + {3'b000, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rdc_cfg_regs.sv @@
`default_nettype none

// Configuration registers behind a simple APB slave. Only the word address
// bit selects the register; the byte offset bits are ignored.
module rdc_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rdc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rdc_pkg::DATA_W-1:0] pwdata,
  output logic      [rdc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output rdc_pkg::cfg_t                   cfg_o
);

  logic [rdc_pkg::CFG_W-1:0] base_q;
  logic [rdc_pkg::CFG_W-1:0] frac_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rdc_pkg::BASE_RESET;
      frac_q <= rdc_pkg::FRAC_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        rdc_pkg::REG_BASE: base_q <= pwdata[rdc_pkg::CFG_W-1:0];
        rdc_pkg::REG_FRAC: frac_q <= pwdata[rdc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rdc_pkg::REG_BASE: prdata = rdc_pkg::DATA_W'(base_q);
      rdc_pkg::REG_FRAC: prdata = rdc_pkg::DATA_W'(frac_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.base        = base_q;
  assign cfg_o.frac_digits = frac_q;

endmodule

`default_nettype wire

@@ rtl/core/rdc_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend register is
// shifted left and refilled with quotient bits, so it ends up holding the
// quotient. The remainder is always below the base and fits in four bits.
module rdc_divider #(
  parameter int INT_BITS = rdc_pkg::INT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [INT_BITS-1:0]       dividend_i,
  input  wire logic [rdc_pkg::CFG_W-1:0] base_i,
  output logic      [INT_BITS-1:0]       quotient_o,
  output rdc_pkg::div_res_t              res_o
);

  localparam int CW = $clog2(INT_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(INT_BITS - 1);

  logic                run_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [INT_BITS-1:0] dq_q;
  logic [3:0]          rem_q;
  logic [4:0]          trial;
  logic                ge;

  assign trial = {rem_q, dq_q[INT_BITS-1]};
  assign ge    = (trial >= base_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == LAST_STEP) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      dq_q  <= {dq_q[INT_BITS-2:0], ge};
      rem_q <= ge ? 4'(trial - base_i) : trial[3:0];
    end
  end

  assign quotient_o = dq_q;
  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;

endmodule

`default_nettype wire

@@ rtl/core/radix_digit_converter.sv @@
`default_nettype none

// Radix digit converter: one signed fixed-point number in, a string of ASCII
// characters out (sign, space, integer digits, dot, fraction digits).
//
//   Channel   Direction  Handshake                    Payload
//   --------  ---------  ---------------------------  --------------------------------
//   number    in         start, busy                  negative_i, integer_part_i,
//                                                     fraction_part_i
//   chars     out        result_strobe_o (one cycle)  character_o, last_o
//   config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// A transaction on the number channel completes at a clock edge where start is
// high and busy is low. The integer part is taken apart by a shared restoring
// divider that yields one quotient bit a cycle, one division per integer digit.
// Busy stays high from acceptance until the final character has been emitted;
// characters leave at one per cycle once the divisions are done.
// Reset is asynchronous and active low; it restores base 10 and six fraction
// digits. The receiver cannot stall: every strobed character is taken.
module radix_digit_converter #(
  parameter int INT_BITS  = rdc_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = rdc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // number channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       negative_i,
  input  wire logic [30:0]                integer_part_i,
  input  wire logic [31:0]                fraction_part_i,
  // character channel
  output logic                            result_strobe_o,
  output logic      [6:0]                 character_o,
  output logic                            last_o,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rdc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rdc_pkg::DATA_W-1:0] pwdata,
  output logic      [rdc_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CNT_W = $clog2(INT_BITS + 1);
  localparam int IDX_W = $clog2(INT_BITS);
  localparam int PROD_W = FRAC_BITS + 4;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_SIGN  = 3'd2;
  localparam logic [2:0] S_SPACE = 3'd3;
  localparam logic [2:0] S_INT   = 3'd4;
  localparam logic [2:0] S_DOT   = 3'd5;
  localparam logic [2:0] S_FRAC  = 3'd6;

  rdc_pkg::cfg_t             cfg;
  rdc_pkg::div_res_t         div_res;
  logic [rdc_pkg::CFG_W-1:0] eb;
  logic [rdc_pkg::CFG_W-1:0] lim;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     nd_q, nd_d;
  logic [4:0]           fcnt_q, fcnt_d;
  logic                 first_q, first_d;
  logic                 sign_q, sign_d;
  logic [FRAC_BITS-1:0] fr_q, fr_d;
  logic [3:0]           digs_q [INT_BITS];

  logic                 strobe_q;
  logic [6:0]           char_q;
  logic                 last_q;

  logic                 accept;
  logic                 emit;
  logic [6:0]           emit_char;
  logic                 emit_last;
  logic                 div_start;
  logic                 push;
  logic [INT_BITS-1:0]  div_dividend;
  logic [INT_BITS-1:0]  div_quot;
  logic [IDX_W-1:0]     pop_idx;
  logic [IDX_W-1:0]     push_idx;
  logic [PROD_W-1:0]    prod;
  logic                 frac_zero;

  rdc_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Out-of-range settings are saturated here rather than at write time, so a
  // read returns the low CFG_W bits exactly as written.
  assign eb  = rdc_pkg::eff_base(cfg.base);
  assign lim = rdc_pkg::eff_limit(cfg.frac_digits);

  // The divider is restarted on its own quotient until that reaches zero.
  assign div_dividend = (state_q == S_IDLE) ? integer_part_i[INT_BITS-1:0] : div_quot;

  rdc_divider #(
    .INT_BITS (INT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .base_i     (eb),
    .quotient_o (div_quot),
    .res_o      (div_res)
  );

  assign busy     = (state_q != S_IDLE);
  assign accept   = start & ~busy;
  assign pop_idx  = IDX_W'(nd_q - CNT_W'(1));
  assign push_idx = IDX_W'(nd_q);

  // One fraction digit per cycle: the integer part of fraction times base is
  // the digit and the low FRAC_BITS bits carry on as the new fraction.
  assign prod      = PROD_W'(fr_q) * PROD_W'(eb);
  assign frac_zero = (prod[FRAC_BITS-1:0] == '0);

  always_comb begin
    state_d   = state_q;
    nd_d      = nd_q;
    fcnt_d    = fcnt_q;
    first_d   = first_q;
    sign_d    = sign_q;
    fr_d      = fr_q;
    emit      = 1'b0;
    emit_char = '0;
    emit_last = 1'b0;
    div_start = 1'b0;
    push      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sign_d    = negative_i;
          fr_d      = fraction_part_i[FRAC_BITS-1:0];
          nd_d      = '0;
          fcnt_d    = '0;
          first_d   = 1'b1;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        // Digits are produced least significant first and stacked, so that
        // they can be popped most significant first.
        if (div_res.done) begin
          push = 1'b1;
          nd_d = nd_q + CNT_W'(1);
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else begin
            state_d = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        emit      = 1'b1;
        emit_char = sign_q ? rdc_pkg::CH_MINUS : rdc_pkg::CH_PLUS;
        state_d   = S_SPACE;
      end
      S_SPACE: begin
        emit      = 1'b1;
        emit_char = rdc_pkg::CH_SPACE;
        state_d   = S_INT;
      end
      S_INT: begin
        // Only the leading digit uses upper case letters.
        emit      = 1'b1;
        emit_char = rdc_pkg::digit_char(digs_q[pop_idx], first_q);
        first_d   = 1'b0;
        nd_d      = nd_q - CNT_W'(1);
        if (nd_q == CNT_W'(1)) begin
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        // With nothing to print after it, the dot ends the number.
        emit      = 1'b1;
        emit_char = rdc_pkg::CH_DOT;
        emit_last = (fr_q == '0) || (lim == '0);
        state_d   = emit_last ? S_IDLE : S_FRAC;
      end
      S_FRAC: begin
        emit      = 1'b1;
        emit_char = rdc_pkg::digit_char(prod[FRAC_BITS+3:FRAC_BITS], 1'b0);
        fr_d      = prod[FRAC_BITS-1:0];
        fcnt_d    = fcnt_q + 5'd1;
        emit_last = frac_zero || ((fcnt_q + 5'd1) == lim);
        if (emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nd_q     <= '0;
      fcnt_q   <= '0;
      first_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nd_q     <= nd_d;
      fcnt_q   <= fcnt_d;
      first_q  <= first_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
    fr_q   <= fr_d;
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
    if (push) begin
      digs_q[push_idx] <= div_res.rem;
    end
  end

  assign result_strobe_o = strobe_q;
  assign character_o     = char_q;
  assign last_o          = last_q;

`ifndef SYNTH
  // The final character of a number leaves the sequencer idle.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |-> (state_q == S_IDLE))
    else $error("final character strobed while sequencer still active");

  // Characters only come from a number that is being worked on.
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(busy))
    else $error("character strobed without a number in progress");

  // An accepted number never produces a character in the next cycle.
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !strobe_q)
    else $error("character strobed straight after accepting a number");

  // The divider only finishes while the sequencer waits for it.
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV))
    else $error("divider finished outside the division phase");
`endif

endmodule

`default_nettype wire

@@ tb/sv/radix_digit_converter_test.sv @@
`timescale 1ns / 1ps

module radix_digit_converter_test;

  // The worst case per number is set by 31 binary digits through the bit-serial
  // divider, 30 fraction digits and the longest gap. The run holds about 110
  // numbers, and the limit below is several times their worst-case total.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Byte addresses of the two registers: the word index sits above two zero bits.
  localparam logic [rdc_pkg::ADDR_W-1:0] BASE_ADDR = {rdc_pkg::REG_BASE, 2'b00};
  localparam logic [rdc_pkg::ADDR_W-1:0] FRAC_ADDR = {rdc_pkg::REG_FRAC, 2'b00};

  // One number waiting to be offered to the block.
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
    logic [31:0] frac;
  } number_t;

  // One character that the block is expected to emit.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_t;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       start           = 1'b0;
  logic                       busy;
  logic                       negative_i      = 1'b0;
  logic [30:0]                integer_part_i  = '0;
  logic [31:0]                fraction_part_i = '0;
  logic                       result_strobe_o;
  logic [6:0]                 character_o;
  logic                       last_o;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [rdc_pkg::ADDR_W-1:0] paddr           = '0;
  logic [rdc_pkg::DATA_W-1:0] pwdata          = '0;
  logic [rdc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Numbers not yet offered, and the characters predicted for accepted numbers.
  number_t pending_numbers[$];
  char_t   expected_chars[$];

  // The testbench's own copy of the two configuration registers.
  logic [rdc_pkg::CFG_W-1:0] cfg_base = rdc_pkg::BASE_RESET;
  logic [rdc_pkg::CFG_W-1:0] cfg_frac = rdc_pkg::FRAC_RESET;

  int errors      = 0;
  int cycle_count = 0;
  int gap_left    = 0;
  bit gaps_on     = 1'b1;

  radix_digit_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .negative_i      (negative_i),
    .integer_part_i  (integer_part_i),
    .fraction_part_i (fraction_part_i),
    .result_strobe_o (result_strobe_o),
    .character_o     (character_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ASCII for one digit value. Letters start at ten, so the offset from the
  // letter base is the digit less ten.
  function automatic logic [6:0] to_ascii(input logic [3:0] d, input logic upper);
    logic [6:0] letter;
    letter = upper ? rdc_pkg::CH_UPPER : rdc_pkg::CH_LOWER;
    if (d > 4'd9) begin
      return letter + 7'(d - 4'd10);
    end
    return rdc_pkg::CH_ZERO + 7'(d);
  endfunction

  // Works out the whole string for one number under the current settings and
  // appends it to the queue of expected characters.
  function automatic void predict_number(input logic neg, input logic [30:0] int_mag,
                                         input logic [31:0] frac_in);
    logic [rdc_pkg::CFG_W-1:0] radix;
    logic [rdc_pkg::CFG_W-1:0] max_frac;
    logic [63:0]               rest;
    logic [63:0]               frac;
    logic [63:0]               prod;
    logic [3:0]                digits[$];
    logic [6:0]                line[$];
    int                        count;
    char_t                     c;
    // Out-of-range settings saturate rather than wrap.
    radix = cfg_base;
    if (cfg_base < rdc_pkg::BASE_MIN) begin
      radix = rdc_pkg::BASE_MIN;
    end else if (cfg_base > rdc_pkg::BASE_MAX) begin
      radix = rdc_pkg::BASE_MAX;
    end
    max_frac = (cfg_frac > rdc_pkg::FRAC_MAX) ? rdc_pkg::FRAC_MAX : cfg_frac;
    // Integer digits, most significant first; zero still gives one digit.
    rest = 64'(int_mag);
    do begin
      digits.push_front(4'(rest % radix));
      rest = rest / radix;
    end while (rest != 0);
    line.push_back(neg ? rdc_pkg::CH_MINUS : rdc_pkg::CH_PLUS);
    line.push_back(rdc_pkg::CH_SPACE);
    foreach (digits[k]) begin
      line.push_back(to_ascii(digits[k], k == 0));
    end
    line.push_back(rdc_pkg::CH_DOT);
    // Fraction digits: each multiply by the radix pushes one digit above bit 31.
    frac  = 64'(frac_in);
    count = 0;
    while (frac != 0 && count < max_frac) begin
      prod = frac * radix;
      line.push_back(to_ascii(prod[35:32], 1'b0));
      frac = prod & 64'hFFFF_FFFF;
      count++;
    end
    foreach (line[k]) begin
      c.ch   = line[k];
      c.last = (k == line.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Driver. A number stays on the port with start high until the block takes
  // it; start may well rise while busy is high, so numbers land on every phase
  // of the conversion. When start is low the payload carries junk.
  always @(posedge clk_i) begin
    number_t nxt;
    logic    took;
    took = start && !busy;
    if (took) begin
      predict_number(negative_i, integer_part_i, fraction_part_i);
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // Hold the offered number until the block is free.
    end else if (gap_left != 0 || pending_numbers.size() == 0) begin
      if (gap_left != 0) begin
        gap_left--;
      end
      start           <= 1'b0;
      negative_i      <= 1'($urandom);
      integer_part_i  <= 31'($urandom);
      fraction_part_i <= $urandom;
    end else begin
      nxt             = pending_numbers.pop_front();
      start           <= 1'b1;
      negative_i      <= nxt.neg;
      integer_part_i  <= nxt.mag;
      fraction_part_i <= nxt.frac;
      // Now and then leave a gap after this number has gone in.
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(1, 19);
      end
    end
  end

  // Monitor. Every strobed character is taken and compared with the oldest
  // expectation; the receiver has no way of holding characters back.
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, character_o, last_o);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.ch) begin
          $display("%0t: character mismatch, expected %h, actual %h",
                   $time, want.ch, character_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last flag mismatch, expected %b, actual %b",
                   $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL radix_digit_converter");
      $finish;
    end
  end

  // One APB transfer: a setup phase, then an access phase that ends at the
  // edge where pready is seen high. Read data is taken at that edge.
  task automatic apb_access(input logic wr, input logic [rdc_pkg::ADDR_W-1:0] addr,
                            input logic [rdc_pkg::DATA_W-1:0] wdata,
                            output logic [rdc_pkg::DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits, at falling edges so that nothing races the clocked blocks, until
  // no number is waiting or in flight and every character has come out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_numbers.size() != 0 || start || busy || expected_chars.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes both registers while the block is idle and reads them back. The
  // upper bits of the write data are junk, since only the low field is kept.
  task automatic set_config(input logic [rdc_pkg::CFG_W-1:0] b,
                            input logic [rdc_pkg::CFG_W-1:0] f);
    logic [rdc_pkg::DATA_W-1:0] wd;
    logic [rdc_pkg::DATA_W-1:0] rd;
    wait_drained();
    wd = $urandom;
    wd[rdc_pkg::CFG_W-1:0] = b;
    apb_access(1'b1, BASE_ADDR, wd, rd);
    cfg_base = b;
    wd = $urandom;
    wd[rdc_pkg::CFG_W-1:0] = f;
    apb_access(1'b1, FRAC_ADDR, wd, rd);
    cfg_frac = f;
    apb_access(1'b0, BASE_ADDR, $urandom, rd);
    if (rd[rdc_pkg::CFG_W-1:0] !== b) begin
      $display("%0t: base read back mismatch, expected %h, actual %h", $time, b, rd);
      errors++;
    end
    apb_access(1'b0, FRAC_ADDR, $urandom, rd);
    if (rd[rdc_pkg::CFG_W-1:0] !== f) begin
      $display("%0t: frac_digits read back mismatch, expected %h, actual %h",
               $time, f, rd);
      errors++;
    end
    @(negedge clk_i);
  endtask

  task automatic enqueue(input logic neg, input logic [30:0] mag, input logic [31:0] frac);
    number_t n;
    n.neg  = neg;
    n.mag  = mag;
    n.frac = frac;
    pending_numbers.push_back(n);
  endtask

  // Main sequence: reset, directed numbers over a run of extreme settings,
  // then random settings with random numbers, the last phase without gaps.
  initial begin
    logic [30:0] mag;
    logic [31:0] frac;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Settings straight out of reset: base ten, six fraction digits.
    enqueue(1'b0, 31'd0, 32'd0);                    // zero integer, zero fraction
    enqueue(1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);    // both fields at their maximum
    enqueue(1'b0, 31'd123456789, 32'h8000_0000);    // exactly one half
    enqueue(1'b1, 31'd0, 32'h0000_0001);            // cut short by the digit limit
    enqueue(1'b0, 31'd7, 32'h4000_0000);

    set_config(5'd16, 5'd30);
    enqueue(1'b0, 31'h00AB_CDEF, 32'hFFFF_FFFF);    // capital letter only in front
    enqueue(1'b1, 31'h7FFF_FFFF, 32'h1234_5678);

    // Binary with a frac_digits of 31, which is held at 30: the longest string.
    set_config(5'd2, 5'd31);
    enqueue(1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    enqueue(1'b0, 31'd0, 32'h8000_0000);

    // Base zero saturates to two; no fraction digits, so the dot ends it.
    set_config(5'd0, 5'd0);
    enqueue(1'b0, 31'd5, 32'hDEAD_BEEF);
    enqueue(1'b1, 31'd0, 32'd0);

    set_config(5'd1, 5'd3);
    enqueue(1'b0, 31'd255, 32'h5555_5555);

    // Bases above sixteen saturate to sixteen.
    set_config(5'd31, 5'd8);
    enqueue(1'b0, 31'h7FFF_FFFF, 32'hC000_0000);
    enqueue(1'b1, 31'd15, 32'd0);

    set_config(5'd17, 5'd30);
    enqueue(1'b0, 31'h0F0F_0F0F, 32'h0000_0010);

    set_config(5'd15, 5'd12);
    enqueue(1'b1, 31'd14, 32'hAAAA_AAAA);
    enqueue(1'b0, 31'd224, 32'h0000_0001);

    set_config(5'd3, 5'd20);
    enqueue(1'b0, 31'h7FFF_FFFF, 32'h5555_5555);

    // Random part: each phase picks settings, mostly legal bases with the
    // occasional saturating one, then a batch of mixed-shape numbers.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        gaps_on = 1'b0;
      end
      set_config(($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(2, 16)),
                 5'($urandom_range(0, 31)));
      for (int n = 0; n < 11; n++) begin
        case ($urandom_range(0, 3))
          0:       mag = 31'($urandom);
          1:       mag = 31'($urandom_range(0, 255));
          2:       mag = 31'($urandom >> $urandom_range(0, 31));
          default: mag = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0;
        endcase
        case ($urandom_range(0, 3))
          0:       frac = $urandom;
          1:       frac = 32'd0;
          2:       frac = $urandom << $urandom_range(0, 31);
          default: frac = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                               : 32'h1 << $urandom_range(0, 31);
        endcase
        enqueue(1'($urandom), mag, frac);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASS radix_digit_converter");
    end else begin
      $display("FAIL radix_digit_converter");
    end
    $finish;
  end

endmodule
